@@ design/hsd_pkg.sv @@
// Shared types, codes and helper functions of the hit stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package hsd_pkg;

    localparam int BlockBits   = 64;
    localparam int PayloadBits = BlockBits - 1;
    localparam int BufBits     = 2 * BlockBits;

    typedef struct packed {
        logic                   new_stream;
        logic [PayloadBits-1:0] payload;
    } item_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [7:0]  stream_tag;
        logic [5:0]  core_column;
        logic [7:0]  quarter_row;
        logic [15:0] hit_map;
        logic [4:0]  hit_count;
        logic [63:0] tot_values;
        logic [10:0] internal_tag;
        logic        last_of_run;
    } result_t;

    // record kinds
    localparam logic [2:0] KIND_START = 3'd0;
    localparam logic [2:0] KIND_HIT   = 3'd1;
    localparam logic [2:0] KIND_PREC  = 3'd2;
    localparam logic [2:0] KIND_ITAG  = 3'd3;
    localparam logic [2:0] KIND_END   = 3'd4;

    // bit buffer operations
    localparam logic [2:0] BOP_NONE   = 3'd0;
    localparam logic [2:0] BOP_TAKE   = 3'd1;
    localparam logic [2:0] BOP_LOAD   = 3'd2;
    localparam logic [2:0] BOP_APPEND = 3'd3;
    localparam logic [2:0] BOP_CLEAR  = 3'd4;

    localparam logic [6:0] BUF_CAP       = 7'd127;
    localparam logic [3:0] MAX_RESULTS   = 4'd8;
    localparam logic [3:0] OLD_LIMIT     = 4'd6;
    localparam logic [5:0] ITAG_MIN      = 6'h38;
    localparam logic [7:0] PRECISION_ROW = 8'd196;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] take_n;
    } buf_ctl_t;

    typedef struct packed {
        logic push;
        logic flush;
    } rq_ctl_t;

    typedef struct packed {
        logic can_push;
        logic hold_empty;
    } rq_stat_t;

    function automatic logic [7:0] tree_mask(input logic [1:0] lv, input logic [2:0] s);
        logic [7:0] m;
        m = 8'h00;
        case (lv)
            2'd0:
            begin
                case (s)
                    3'd0:    m = 8'hF0;
                    3'd4:    m = 8'h0F;
                    default: m = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (s)
                    3'd0:    m = 8'hCF;
                    3'd2:    m = 8'h3F;
                    3'd4:    m = 8'hFC;
                    3'd6:    m = 8'hF3;
                    default: m = 8'h00;
                endcase
            end
            default:
            begin
                case (s)
                    3'd0:    m = 8'hBF;
                    3'd1:    m = 8'h7F;
                    3'd2:    m = 8'hEF;
                    3'd3:    m = 8'hDF;
                    3'd4:    m = 8'hFB;
                    3'd5:    m = 8'hF7;
                    3'd6:    m = 8'hFE;
                    default: m = 8'hFD;
                endcase
            end
        endcase
        return m;
    endfunction

    function automatic logic [4:0] popcount16(input logic [15:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 16; i++)
        begin
            n = n + {4'd0, v[i]};
        end
        return n;
    endfunction

endpackage
`default_nettype wire

@@ design/pixel_hit_stream_decoder_top.sv @@
// Top level of the pixel hit stream decoder: field sequencer and tree walk.
//
// Usage: link blocks enter on the item channel (new_stream bit and 63 payload
// bits); decoded records leave on the result channel, one word per record,
// last_of_run set on the final word caused by a block. A block may cause no
// words at all. cfg_data writes compressed_mode (reset 1) on the cfg channel,
// which is always ready; write it only while the block is idle.
// Sequence: after the accept a block is loaded (a new-stream block that closes
// an open stream parses the old bits first and loads after the close), then
// each parsed field, tree node pair, ToT nibble or record takes a step, the
// parser finds the bits run short, and the flush releases the last word
// before the return to idle. The buffer holds at most 127 bits. The rate is
// set by the single field shifter of the bit buffer, which extracts one field
// per cycle unless a record waits for room in the result queue. item_ready is
// high only while idle; one word can wait in the output register while the
// next block is accepted.
// Reset clears the bit buffer and parser, and waits for a stream start.
// A stalled receiver holds the parser whenever a new record has to be
// produced with both the hold stage and the output register full.
`timescale 1ns / 1ps
`default_nettype none
module pixel_hit_stream_decoder_top
    import hsd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  wire item_t item,
    output logic       result_valid,
    input  wire logic  result_ready,
    output result_t    result,
    input  wire logic  cfg_valid,
    output logic       cfg_ready,
    input  wire logic  cfg_data
);

    localparam logic [2:0] SQ_IDLE  = 3'd0;
    localparam logic [2:0] SQ_LOAD  = 3'd1;
    localparam logic [2:0] SQ_PARSE = 3'd2;
    localparam logic [2:0] SQ_CLOSE = 3'd3;
    localparam logic [2:0] SQ_FLUSH = 3'd4;

    localparam logic [3:0] PH_WAIT   = 4'd0;
    localparam logic [3:0] PH_TAG    = 4'd1;
    localparam logic [3:0] PH_CCOL   = 4'd2;
    localparam logic [3:0] PH_ITAG   = 4'd3;
    localparam logic [3:0] PH_FLAGS  = 4'd4;
    localparam logic [3:0] PH_QROW   = 4'd5;
    localparam logic [3:0] PH_RAWMAP = 4'd6;
    localparam logic [3:0] PH_ROOT   = 4'd7;
    localparam logic [3:0] PH_TREE   = 4'd8;
    localparam logic [3:0] PH_TOT    = 4'd9;

    logic [2:0]  seq_reg, seq_next;
    logic [3:0]  phase_reg, phase_next;
    logic        pass2_reg, pass2_next;
    logic [3:0]  rcnt_reg, rcnt_next;
    item_t       item_reg, item_next;
    logic        mode_reg;
    logic [5:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;
    logic [15:0] map_reg, map_next;
    logic [63:0] acc_reg, acc_next;
    logic        last_reg, last_next;
    logic [1:0]  rows_left_reg, rows_left_next;
    logic        row_sel_reg, row_sel_next;
    logic [1:0]  level_reg, level_next;
    logic [2:0]  node_cnt_reg, node_cnt_next;
    logic [2:0]  node_idx_reg, node_idx_next;
    logic [2:0]  next_cnt_reg, next_cnt_next;
    logic [7:0]  row_bits_reg, row_bits_next;
    logic [15:0] pend_reg, pend_next;
    logic [3:0]  tot_idx_reg, tot_idx_next;
    logic        prec_reg, prec_next;
    logic        bank_reg, bank_next;
    logic [2:0]  queue_mem [16];

    logic        qw0_en, qw1_en;
    logic [3:0]  qw0_addr, qw1_addr;
    logic [2:0]  qw0_data, qw1_data;

    buf_ctl_t    bctl;
    logic [15:0] win;
    logic [6:0]  bcnt;
    rq_ctl_t     qctl;
    rq_stat_t    qstat;
    result_t     res;

    logic        pair_avail;
    logic [1:0]  pair_val;
    logic [4:0]  pair_take;
    logic [2:0]  s_cur, s_alt;
    logic [7:0]  mask_lo, mask_hi, mask_sel, rb;
    logic        deeper;
    logic [3:0]  low_bit;
    logic [3:0]  limit;
    logic        stop, go_row, go_tot;
    logic [1:0]  rl_in;
    logic [2:0]  idx_inc;

    assign item_ready = (seq_reg == SQ_IDLE);
    assign cfg_ready  = 1'b1;
    assign limit      = pass2_reg ? MAX_RESULTS : OLD_LIMIT;

    // bit pair of the tree code: a lone 0 means 01
    assign pair_avail = (bcnt != 7'd0) && (!win[15] || (bcnt >= 7'd2));
    assign pair_val   = win[15] ? win[15:14] : 2'd1;
    assign pair_take  = win[15] ? 5'd2 : 5'd1;

    assign s_cur    = queue_mem[{bank_reg, node_idx_reg}];
    assign s_alt    = s_cur + (3'd4 >> level_reg);
    assign mask_lo  = tree_mask(level_reg, s_cur);
    assign mask_hi  = tree_mask(level_reg, s_alt);
    assign deeper   = (level_reg < 2'd2);
    assign mask_sel = (pair_val == 2'd1) ? mask_lo :
                      (pair_val == 2'd2) ? mask_hi : (mask_lo | mask_hi);
    assign rb       = row_bits_reg & mask_sel;
    assign idx_inc  = node_idx_reg + 3'd1;

    always_comb
    begin
        low_bit = 4'd15;
        for (int i = 15; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                low_bit = 4'(i);
            end
        end
    end

    always_comb
    begin
        seq_next       = seq_reg;
        phase_next     = phase_reg;
        pass2_next     = pass2_reg;
        rcnt_next      = rcnt_reg;
        item_next      = item_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        map_next       = map_reg;
        acc_next       = acc_reg;
        last_next      = last_reg;
        rows_left_next = rows_left_reg;
        row_sel_next   = row_sel_reg;
        level_next     = level_reg;
        node_cnt_next  = node_cnt_reg;
        node_idx_next  = node_idx_reg;
        next_cnt_next  = next_cnt_reg;
        row_bits_next  = row_bits_reg;
        pend_next      = pend_reg;
        tot_idx_next   = tot_idx_reg;
        prec_next      = prec_reg;
        bank_next      = bank_reg;
        bctl.op        = BOP_NONE;
        bctl.take_n    = 5'd0;
        qctl.push      = 1'b0;
        qctl.flush     = 1'b0;
        res            = '0;
        qw0_en         = 1'b0;
        qw0_addr       = {~bank_reg, next_cnt_reg};
        qw0_data       = s_cur;
        qw1_en         = 1'b0;
        qw1_addr       = {~bank_reg, next_cnt_reg + 3'd1};
        qw1_data       = s_cur;
        stop           = 1'b0;
        go_row         = 1'b0;
        go_tot         = 1'b0;
        rl_in          = rows_left_reg;

        case (seq_reg)
            SQ_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                    rcnt_next = 4'd0;
                    if (item.new_stream && (phase_reg != PH_WAIT))
                    begin
                        pass2_next = 1'b0;
                        seq_next   = SQ_PARSE;
                    end
                    else
                    begin
                        seq_next = SQ_LOAD;
                    end
                end
            end
            SQ_LOAD:
            begin
                if ((phase_reg == PH_WAIT) || item_reg.new_stream)
                begin
                    bctl.op    = BOP_LOAD;
                    phase_next = PH_TAG;
                end
                else
                begin
                    bctl.op = BOP_APPEND;
                end
                pass2_next = 1'b1;
                seq_next   = SQ_PARSE;
            end
            SQ_PARSE:
            begin
                if (rcnt_reg >= limit)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    case (phase_reg)
                        PH_TAG:
                        begin
                            if (bcnt < 7'd8)
                            begin
                                stop = 1'b1;
                            end
                            else if (qstat.can_push)
                            begin
                                res.record_kind = KIND_START;
                                res.stream_tag  = win[15:8];
                                qctl.push       = 1'b1;
                                rcnt_next       = rcnt_reg + 4'd1;
                                bctl.op         = BOP_TAKE;
                                bctl.take_n     = 5'd8;
                                phase_next      = PH_CCOL;
                            end
                        end
                        PH_CCOL:
                        begin
                            if (bcnt < 7'd6)
                            begin
                                stop = 1'b1;
                            end
                            else if (win[15:10] == 6'd0)
                            begin
                                // explicit end: drop the rest of the buffer
                                if (qstat.can_push)
                                begin
                                    res.record_kind = KIND_END;
                                    qctl.push       = 1'b1;
                                    rcnt_next       = rcnt_reg + 4'd1;
                                    bctl.op         = BOP_CLEAR;
                                    phase_next      = PH_WAIT;
                                    stop            = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next    = win[15:10];
                                bctl.op     = BOP_TAKE;
                                bctl.take_n = 5'd6;
                                phase_next  = (win[15:10] >= ITAG_MIN) ? PH_ITAG : PH_FLAGS;
                            end
                        end
                        PH_ITAG:
                        begin
                            if (bcnt < 7'd5)
                            begin
                                stop = 1'b1;
                            end
                            else if (qstat.can_push)
                            begin
                                res.record_kind  = KIND_ITAG;
                                res.internal_tag = {col_reg, win[15:11]};
                                qctl.push        = 1'b1;
                                rcnt_next        = rcnt_reg + 4'd1;
                                bctl.op          = BOP_TAKE;
                                bctl.take_n      = 5'd5;
                                phase_next       = PH_CCOL;
                            end
                        end
                        PH_FLAGS:
                        begin
                            if (bcnt < 7'd2)
                            begin
                                stop = 1'b1;
                            end
                            else
                            begin
                                bctl.op     = BOP_TAKE;
                                bctl.take_n = 5'd2;
                                last_next   = win[15];
                                if (win[14])
                                begin
                                    row_next   = row_reg + 8'd1;
                                    phase_next = mode_reg ? PH_ROOT : PH_RAWMAP;
                                end
                                else
                                begin
                                    phase_next = PH_QROW;
                                end
                            end
                        end
                        PH_QROW:
                        begin
                            if (bcnt < 7'd8)
                            begin
                                stop = 1'b1;
                            end
                            else
                            begin
                                bctl.op     = BOP_TAKE;
                                bctl.take_n = 5'd8;
                                row_next    = win[15:8];
                                phase_next  = mode_reg ? PH_ROOT : PH_RAWMAP;
                            end
                        end
                        PH_RAWMAP:
                        begin
                            if (bcnt < 7'd16)
                            begin
                                stop = 1'b1;
                            end
                            else
                            begin
                                bctl.op     = BOP_TAKE;
                                bctl.take_n = 5'd16;
                                map_next    = win;
                                go_tot      = 1'b1;
                            end
                        end
                        PH_ROOT:
                        begin
                            if (!pair_avail)
                            begin
                                stop = 1'b1;
                            end
                            else
                            begin
                                bctl.op     = BOP_TAKE;
                                bctl.take_n = pair_take;
                                map_next    = 16'd0;
                                rl_in       = pair_val;
                                go_row      = 1'b1;
                            end
                        end
                        PH_TREE:
                        begin
                            if (!pair_avail)
                            begin
                                stop = 1'b1;
                            end
                            else
                            begin
                                bctl.op     = BOP_TAKE;
                                bctl.take_n = pair_take;
                                if (deeper)
                                begin
                                    case (pair_val)
                                        2'd1:
                                        begin
                                            qw0_en        = 1'b1;
                                            qw0_data      = s_cur;
                                            next_cnt_next = next_cnt_reg + 3'd1;
                                        end
                                        2'd2:
                                        begin
                                            qw0_en        = 1'b1;
                                            qw0_data      = s_alt;
                                            next_cnt_next = next_cnt_reg + 3'd1;
                                        end
                                        default:
                                        begin
                                            qw0_en        = 1'b1;
                                            qw0_data      = s_alt;
                                            qw1_en        = 1'b1;
                                            qw1_data      = s_cur;
                                            next_cnt_next = next_cnt_reg + 3'd2;
                                        end
                                    endcase
                                end
                                node_idx_next = idx_inc;
                                row_bits_next = rb;
                                if (idx_inc >= node_cnt_reg)
                                begin
                                    if (!deeper)
                                    begin
                                        map_next = map_reg |
                                            (row_sel_reg ? {rb, 8'h00} : {8'h00, rb});
                                        go_row   = 1'b1;
                                    end
                                    else
                                    begin
                                        // swap node banks for the next level
                                        node_cnt_next = next_cnt_next;
                                        next_cnt_next = 3'd0;
                                        node_idx_next = 3'd0;
                                        level_next    = level_reg + 2'd1;
                                        bank_next     = ~bank_reg;
                                    end
                                end
                            end
                        end
                        PH_TOT:
                        begin
                            if (pend_reg == 16'd0)
                            begin
                                if (qstat.can_push)
                                begin
                                    res.record_kind = prec_reg ? KIND_PREC : KIND_HIT;
                                    res.core_column = col_reg;
                                    res.quarter_row = row_reg;
                                    res.hit_map     = map_reg;
                                    res.hit_count   = popcount16(map_reg);
                                    res.tot_values  = acc_reg;
                                    qctl.push       = 1'b1;
                                    rcnt_next       = rcnt_reg + 4'd1;
                                    phase_next      = last_reg ? PH_CCOL : PH_FLAGS;
                                end
                            end
                            else if (bcnt < 7'd4)
                            begin
                                stop = 1'b1;
                            end
                            else
                            begin
                                bctl.op     = BOP_TAKE;
                                bctl.take_n = 5'd4;
                                if (prec_reg)
                                begin
                                    acc_next[{low_bit, 2'b00} +: 4] = win[15:12];
                                end
                                else
                                begin
                                    acc_next[{tot_idx_reg, 2'b00} +: 4] = win[15:12];
                                    tot_idx_next = tot_idx_reg + 4'd1;
                                end
                                pend_next = pend_reg & (pend_reg - 16'd1);
                            end
                        end
                        default:
                        begin
                            phase_next = PH_WAIT;
                            stop       = 1'b1;
                        end
                    endcase

                    if (go_row)
                    begin
                        if (rl_in[1] || rl_in[0])
                        begin
                            rows_left_next = rl_in[1] ? {1'b0, rl_in[0]} : 2'd0;
                            row_sel_next   = !rl_in[1];
                            level_next     = 2'd0;
                            row_bits_next  = 8'hFF;
                            bank_next      = 1'b0;
                            qw0_en         = 1'b1;
                            qw0_addr       = 4'd0;
                            qw0_data       = 3'd0;
                            node_cnt_next  = 3'd1;
                            node_idx_next  = 3'd0;
                            next_cnt_next  = 3'd0;
                            phase_next     = PH_TREE;
                        end
                        else
                        begin
                            go_tot = 1'b1;
                        end
                    end

                    if (go_tot)
                    begin
                        pend_next    = map_next;
                        tot_idx_next = 4'd0;
                        prec_next    = (row_next == PRECISION_ROW);
                        acc_next     = 64'd0;
                        for (int w = 0; w < 4; w++)
                        begin
                            if ((row_next == PRECISION_ROW) && (map_next[4*w +: 4] != 4'd0))
                            begin
                                acc_next[16*w +: 16] = 16'hFFFF;
                            end
                        end
                        phase_next = PH_TOT;
                    end
                end
                if (stop)
                begin
                    seq_next = pass2_reg ? SQ_FLUSH : SQ_CLOSE;
                end
            end
            SQ_CLOSE:
            begin
                // close the old stream, then load the new block
                if ((phase_reg == PH_WAIT) || qstat.can_push)
                begin
                    if (phase_reg != PH_WAIT)
                    begin
                        res.record_kind = KIND_END;
                        qctl.push       = 1'b1;
                        rcnt_next       = rcnt_reg + 4'd1;
                    end
                    bctl.op    = BOP_LOAD;
                    phase_next = PH_TAG;
                    pass2_next = 1'b1;
                    seq_next   = SQ_PARSE;
                end
            end
            SQ_FLUSH:
            begin
                qctl.flush = 1'b1;
                if (qstat.hold_empty)
                begin
                    seq_next = SQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SQ_IDLE;
            phase_reg     <= PH_WAIT;
            pass2_reg     <= 1'b0;
            rcnt_reg      <= 4'd0;
            mode_reg      <= 1'b1;
            col_reg       <= 6'd0;
            row_reg       <= 8'd0;
            map_reg       <= 16'd0;
            acc_reg       <= 64'd0;
            last_reg      <= 1'b0;
            rows_left_reg <= 2'd0;
            row_sel_reg   <= 1'b0;
            level_reg     <= 2'd0;
            node_cnt_reg  <= 3'd0;
            node_idx_reg  <= 3'd0;
            next_cnt_reg  <= 3'd0;
            row_bits_reg  <= 8'd0;
            pend_reg      <= 16'd0;
            tot_idx_reg   <= 4'd0;
            prec_reg      <= 1'b0;
            bank_reg      <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            pass2_reg     <= pass2_next;
            rcnt_reg      <= rcnt_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            map_reg       <= map_next;
            acc_reg       <= acc_next;
            last_reg      <= last_next;
            rows_left_reg <= rows_left_next;
            row_sel_reg   <= row_sel_next;
            level_reg     <= level_next;
            node_cnt_reg  <= node_cnt_next;
            node_idx_reg  <= node_idx_next;
            next_cnt_reg  <= next_cnt_next;
            row_bits_reg  <= row_bits_next;
            pend_reg      <= pend_next;
            tot_idx_reg   <= tot_idx_next;
            prec_reg      <= prec_next;
            bank_reg      <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (qw0_en)
        begin
            queue_mem[qw0_addr] <= qw0_data;
        end
        if (qw1_en)
        begin
            queue_mem[qw1_addr] <= qw1_data;
        end
    end

    hsd_bitbuf u_bitbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (bctl),
        .payload (item_reg.payload),
        .window  (win),
        .count   (bcnt)
    );

    hsd_result_q u_result_q (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (qctl),
        .push_data    (res),
        .stat         (qstat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("accepted a word while a block was in work");

    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SQ_IDLE) |-> qstat.hold_empty)
        else $error("idle with a result still held");

    a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= MAX_RESULTS)
        else $error("too many results for one block");

    a_tree_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TREE) |-> (node_idx_reg < node_cnt_reg))
        else $error("tree walk index past node count");

endmodule
`default_nettype wire

@@ design/hsd_bitbuf.sv @@
// Pending bit buffer with the shared field shifter: load, append, take, clear.
`timescale 1ns / 1ps
`default_nettype none
module hsd_bitbuf
    import hsd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire buf_ctl_t               ctl,
    input  wire logic [PayloadBits-1:0] payload,
    output logic [15:0]                 window,
    output logic [6:0]                  count
);

    logic [BufBits-1:0] buf_reg, buf_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [BufBits-1:0] blk;
    logic [7:0]         sum;

    assign blk    = {payload, 1'b0, {BlockBits{1'b0}}};
    assign sum    = {1'b0, cnt_reg} + 8'd63;
    assign window = buf_reg[BufBits-1 -: 16];
    assign count  = cnt_reg;

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        case (ctl.op)
            BOP_TAKE:
            begin
                buf_next = buf_reg << ctl.take_n;
                cnt_next = cnt_reg - {2'd0, ctl.take_n};
            end
            BOP_LOAD:
            begin
                buf_next = blk;
                cnt_next = 7'd63;
            end
            BOP_APPEND:
            begin
                if (cnt_reg != BUF_CAP)
                begin
                    buf_next = buf_reg | (blk >> cnt_reg);
                    if (sum > {1'b0, BUF_CAP})
                    begin
                        // drop what does not fit
                        cnt_next    = BUF_CAP;
                        buf_next[0] = 1'b0;
                    end
                    else
                    begin
                        cnt_next = sum[6:0];
                    end
                end
            end
            BOP_CLEAR:
            begin
                buf_next = '0;
                cnt_next = 7'd0;
            end
            default:
            begin
                buf_next = buf_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '0;
            cnt_reg <= 7'd0;
        end
        else
        begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ design/hsd_result_q.sv @@
// Result hold stage and output register; marks the last word of a block on flush.
`timescale 1ns / 1ps
`default_nettype none
module hsd_result_q
    import hsd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire rq_ctl_t ctl,
    input  wire result_t push_data,
    output rq_stat_t     stat,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    logic    hold_v_reg, hold_v_next;
    logic    out_v_reg, out_v_next;
    result_t hold_reg, hold_next;
    result_t out_reg, out_next;
    logic    out_free;

    assign out_free        = !out_v_reg || result_ready;
    assign stat.can_push   = !hold_v_reg || out_free;
    assign stat.hold_empty = !hold_v_reg;
    assign result_valid    = out_v_reg;
    assign result          = out_reg;

    always_comb
    begin
        hold_v_next = hold_v_reg;
        hold_next   = hold_reg;
        out_next    = out_reg;
        out_v_next  = out_v_reg && !result_ready;
        if (ctl.push && stat.can_push)
        begin
            // advance the held word, it is not the last of the block
            if (hold_v_reg)
            begin
                out_next             = hold_reg;
                out_next.last_of_run = 1'b0;
                out_v_next           = 1'b1;
            end
            hold_next   = push_data;
            hold_v_next = 1'b1;
        end
        else if (ctl.flush && hold_v_reg && out_free)
        begin
            out_next             = hold_reg;
            out_next.last_of_run = 1'b1;
            out_v_next           = 1'b1;
            hold_v_next          = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

endmodule
`default_nettype wire
